>>> design/gamepad_serial_poll_master_unit_macros.svh
// Assertion helpers used by the gamepad poll master RTL.
`ifndef GAMEPAD_SERIAL_POLL_MASTER_UNIT_MACROS_SVH
`define GAMEPAD_SERIAL_POLL_MASTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSPM_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GSPM_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gspm_pkg.sv
`default_nettype none

package gspm_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned RX_SLOTS    = 7;
  localparam int unsigned CFG_IDX_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_LEAD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_SETUP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 3'd3;

  localparam logic [7:0] SELECT_LEAD_RST  = 8'd50;
  localparam logic [7:0] DATA_SETUP_RST   = 8'd3;
  localparam logic [7:0] CLOCK_HIGH_RST   = 8'd6;
  localparam logic [7:0] SAMPLE_DELAY_RST = 8'd3;

  // Command frame: first two bytes are fixed, the rest are zero.
  localparam logic [7:0] CMD_BYTE0 = 8'h01;
  localparam logic [7:0] CMD_BYTE1 = 8'h42;
  localparam logic [7:0] CMD_FILL  = 8'h00;

  localparam logic [7:0] BYTE_ALL0 = 8'h00;
  localparam logic [7:0] BYTE_ALL1 = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_SETUP = 3'd2,
    PH_HIGH  = 3'd3,
    PH_LOW   = 3'd4
  } phase_t;

endpackage

`default_nettype wire

>>> design/gamepad_serial_poll_master_unit.sv
// An accepted tick item yields its result item in the output register in the next cycle.
// One tick item per cycle unless out_ready stalls the output; the state update and line
// levels are one combinational pass between the state registers and the output register.
// Reset (rst_n low, synchronous): idle phase, counters and received bytes cleared, timing
// registers back to their defaults, no result pending.
`default_nettype none

`include "gamepad_serial_poll_master_unit_macros.svh"

module gamepad_serial_poll_master_unit
  import gspm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_poll_request,
  input  wire logic                 in_data_in,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_select_level,
  output logic                      out_clock_level,
  output logic                      out_command_level,
  output logic                      out_report_ready,
  output logic                      out_report_valid,
  output logic [7:0]                out_controller_id,
  output logic [7:0]                out_buttons_first,
  output logic [7:0]                out_buttons_second,
  output logic [7:0]                out_right_stick_x,
  output logic [7:0]                out_right_stick_y,
  output logic [7:0]                out_left_stick_x,
  output logic [7:0]                out_left_stick_y
);

  // Timing registers.
  logic [7:0] lead_r, setup_r, high_r, sdelay_r;

  // Frame state.
  phase_t     phase_r, phase_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [3:0] byte_r, byte_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] rx_r [RX_SLOTS];

  logic       in_fire;
  logic [7:0] part_reg, part_lim;
  logic       part_end;
  logic       rx_wr;
  logic [2:0] rx_slot;
  logic       ready_nxt;

  logic       sel_lvl, clk_lvl, cmd_lvl;
  logic [7:0] tx_byte;
  logic [7:0] rx_view [RX_SLOTS];
  logic       all0, all1;

  // Result register.
  logic       out_valid_r;
  logic       sel_r, clk_r, cmd_r, rdy_r, rvalid_r;
  logic [7:0] res_r [RX_SLOTS];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= SELECT_LEAD_RST;
      setup_r  <= DATA_SETUP_RST;
      high_r   <= CLOCK_HIGH_RST;
      sdelay_r <= SAMPLE_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SELECT_LEAD:  lead_r   <= cfg_data;
        CFG_DATA_SETUP:   setup_r  <= cfg_data;
        CFG_CLOCK_HIGH:   high_r   <= cfg_data;
        CFG_SAMPLE_DELAY: sdelay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Length of the current part; a zero register counts as one tick.
  always_comb begin
    unique case (phase_r)
      PH_LEAD:  part_reg = lead_r;
      PH_SETUP: part_reg = setup_r;
      PH_HIGH:  part_reg = high_r;
      PH_LOW:   part_reg = sdelay_r;
      default:  part_reg = 8'd1;
    endcase
    part_lim = (part_reg == 8'd0) ? 8'd1 : part_reg;
    part_end = !(tick_r < part_lim);
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    rx_wr     = 1'b0;
    rx_slot   = 3'd0;
    ready_nxt = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_poll_request) begin
          phase_nxt = PH_LEAD;
          tick_nxt  = 8'd1;
          bit_nxt   = 3'd0;
          byte_nxt  = 4'd0;
          shift_nxt = 8'd0;
        end
      end
      PH_LEAD, PH_SETUP, PH_HIGH: begin
        tick_nxt = part_end ? 8'd1 : tick_r + 8'd1;
        if (part_end) begin
          unique case (phase_r)
            PH_LEAD:  phase_nxt = PH_SETUP;
            PH_SETUP: phase_nxt = PH_HIGH;
            default:  phase_nxt = PH_LOW;
          endcase
        end
      end
      PH_LOW: begin
        tick_nxt = part_end ? 8'd1 : tick_r + 8'd1;
        if (part_end) begin
          shift_nxt = {in_data_in, shift_r[7:1]};
          phase_nxt = PH_SETUP;
          if (bit_r == 3'd7) begin
            // Byte 1 is the controller id; bytes 3 to 8 are the payload.
            if (byte_r == 4'd1) begin
              rx_wr   = 1'b1;
              rx_slot = 3'd0;
            end else if (byte_r >= 4'd3 && byte_r <= 4'(FRAME_BYTES - 1)) begin
              rx_wr   = 1'b1;
              rx_slot = 3'(byte_r - 4'd2);
            end
            bit_nxt = 3'd0;
            if (byte_r >= 4'(FRAME_BYTES - 1)) begin
              ready_nxt = 1'b1;
              phase_nxt = PH_IDLE;
              tick_nxt  = 8'd0;
              byte_nxt  = 4'd0;
            end else begin
              byte_nxt = byte_r + 4'd1;
            end
          end else begin
            bit_nxt = bit_r + 3'd1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = 8'd0;
      end
    endcase
  end

  // Line levels seen after this tick.
  always_comb begin
    unique case (byte_nxt)
      4'd0:    tx_byte = CMD_BYTE0;
      4'd1:    tx_byte = CMD_BYTE1;
      default: tx_byte = CMD_FILL;
    endcase
    sel_lvl = (phase_nxt == PH_IDLE);
    clk_lvl = (phase_nxt == PH_HIGH);
    if (phase_nxt == PH_SETUP || phase_nxt == PH_HIGH || phase_nxt == PH_LOW) begin
      cmd_lvl = tx_byte[bit_nxt];
    end else begin
      cmd_lvl = 1'b1;
    end
  end

  // Received bytes including the one written on this tick, and the payload check.
  always_comb begin
    all0 = 1'b1;
    all1 = 1'b1;
    for (int k = 0; k < RX_SLOTS; k++) begin
      rx_view[k] = (rx_wr && rx_slot == 3'(k)) ? shift_nxt : rx_r[k];
    end
    for (int k = 1; k < RX_SLOTS; k++) begin
      if (rx_view[k] != BYTE_ALL0) all0 = 1'b0;
      if (rx_view[k] != BYTE_ALL1) all1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 8'd0;
      bit_r   <= 3'd0;
      byte_r  <= 4'd0;
      shift_r <= 8'd0;
      for (int k = 0; k < RX_SLOTS; k++) rx_r[k] <= 8'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      for (int k = 0; k < RX_SLOTS; k++) begin
        if (rx_wr && rx_slot == 3'(k)) rx_r[k] <= shift_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Report fields read as zero on every tick that does not complete a frame.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sel_r    <= sel_lvl;
      clk_r    <= clk_lvl;
      cmd_r    <= cmd_lvl;
      rdy_r    <= ready_nxt;
      rvalid_r <= ready_nxt && !(all0 || all1);
      for (int k = 0; k < RX_SLOTS; k++) begin
        res_r[k] <= ready_nxt ? rx_view[k] : 8'd0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_select_level   = sel_r;
  assign out_clock_level    = clk_r;
  assign out_command_level  = cmd_r;
  assign out_report_ready   = rdy_r;
  assign out_report_valid   = rvalid_r;
  assign out_controller_id  = res_r[0];
  assign out_buttons_first  = res_r[1];
  assign out_buttons_second = res_r[2];
  assign out_right_stick_x  = res_r[3];
  assign out_right_stick_y  = res_r[4];
  assign out_left_stick_x   = res_r[5];
  assign out_left_stick_y   = res_r[6];

  `GSPM_ASSERT_NOW(a_idle_clean, clk, rst_n, phase_r == PH_IDLE, tick_r == 8'd0 && bit_r == 3'd0 && byte_r == 4'd0, "idle phase with live counters")
  `GSPM_ASSERT_NOW(a_byte_range, clk, rst_n, 1'b1, byte_r <= 4'(FRAME_BYTES - 1), "byte index past end of frame")
  `GSPM_ASSERT_NEXT(a_done_idle, clk, rst_n, in_fire && ready_nxt, phase_r == PH_IDLE && out_valid_r && rdy_r, "completed frame did not return to idle")
  `GSPM_ASSERT_NOW(a_report_lines, clk, rst_n, out_valid_r && rdy_r, sel_r && !clk_r && cmd_r, "report given while lines not idle")
  `GSPM_ASSERT_NOW(a_clock_in_frame, clk, rst_n, out_valid_r && clk_r, !sel_r, "serial clock high while select is high")

endmodule

`default_nettype wire

>>> verif/gamepad_poll_line_checker.sv
`default_nettype none

module gamepad_poll_line_checker
  import gspm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic                 in_poll_request,
  input  wire logic                 in_data_in,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 out_select_level,
  input  wire logic                 out_clock_level,
  input  wire logic                 out_command_level,
  input  wire logic                 out_report_ready,
  input  wire logic                 out_report_valid,
  input  wire logic [7:0]           out_controller_id,
  input  wire logic [7:0]           out_buttons_first,
  input  wire logic [7:0]           out_buttons_second,
  input  wire logic [7:0]           out_right_stick_x,
  input  wire logic [7:0]           out_right_stick_y,
  input  wire logic [7:0]           out_left_stick_x,
  input  wire logic [7:0]           out_left_stick_y,
  output int unsigned               fail_count,
  output int unsigned               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic       select_level;
    logic       clock_level;
    logic       command_level;
    logic       report_ready;
    logic       report_valid;
    logic [7:0] controller_id;
    logic [7:0] buttons_first;
    logic [7:0] buttons_second;
    logic [7:0] right_stick_x;
    logic [7:0] right_stick_y;
    logic [7:0] left_stick_x;
    logic [7:0] left_stick_y;
  } line_levels_t;

  logic [7:0]   lead_span;
  logic [7:0]   setup_span;
  logic [7:0]   high_span;
  logic [7:0]   sample_span;

  phase_t       frame_phase;
  logic [7:0]   part_ticks;
  logic [2:0]   bit_pos;
  logic [3:0]   byte_pos;
  logic [7:0]   shift_in;
  logic [7:0]   kept_bytes [RX_SLOTS];

  line_levels_t expected_lines [$];

  // Counts ticks within one part of a bit; a span of zero behaves as one tick.
  function automatic bit part_over(input logic [7:0] span);
    logic [7:0] len;
    len = (span == 8'd0) ? 8'd1 : span;
    if (part_ticks < len) begin
      part_ticks = part_ticks + 8'd1;
      return 1'b0;
    end
    part_ticks = 8'd1;
    return 1'b1;
  endfunction

  function automatic line_levels_t next_line_levels(input logic req, input logic din);
    line_levels_t lv;
    logic         done;
    logic         all_low;
    logic         all_high;
    logic [7:0]   cmd_byte;
    done = 1'b0;
    case (frame_phase)
      PH_IDLE: begin
        if (req) begin
          frame_phase = PH_LEAD;
          part_ticks  = 8'd1;
          bit_pos     = '0;
          byte_pos    = '0;
          shift_in    = '0;
        end
      end
      PH_LEAD: if (part_over(lead_span)) frame_phase = PH_SETUP;
      PH_SETUP: if (part_over(setup_span)) frame_phase = PH_HIGH;
      PH_HIGH: if (part_over(high_span)) frame_phase = PH_LOW;
      PH_LOW: begin
        if (part_over(sample_span)) begin
          shift_in = {din, shift_in[7:1]};
          if (bit_pos == 3'd7) begin
            // Bytes 0 and 2 of the reply carry nothing the report uses.
            if (byte_pos == 4'd1) kept_bytes[0] = shift_in;
            else if (byte_pos >= 4'd3) kept_bytes[byte_pos - 4'd2] = shift_in;
            bit_pos = '0;
            if (byte_pos == FRAME_BYTES - 1) begin
              done        = 1'b1;
              frame_phase = PH_IDLE;
              part_ticks  = '0;
              byte_pos    = '0;
            end else begin
              byte_pos    = byte_pos + 4'd1;
              frame_phase = PH_SETUP;
            end
          end else begin
            bit_pos     = bit_pos + 3'd1;
            frame_phase = PH_SETUP;
          end
        end
      end
      default: begin
        frame_phase = PH_IDLE;
        part_ticks  = '0;
      end
    endcase

    lv = '0;
    lv.select_level = (frame_phase == PH_IDLE);
    lv.clock_level  = (frame_phase == PH_HIGH);
    if (byte_pos == 4'd0) cmd_byte = CMD_BYTE0;
    else if (byte_pos == 4'd1) cmd_byte = CMD_BYTE1;
    else cmd_byte = CMD_FILL;
    lv.command_level = (frame_phase inside {PH_SETUP, PH_HIGH, PH_LOW}) ?
                       cmd_byte[bit_pos] : 1'b1;
    if (done) begin
      all_low  = 1'b1;
      all_high = 1'b1;
      for (int k = 1; k < RX_SLOTS; k++) begin
        if (kept_bytes[k] != BYTE_ALL0) all_low = 1'b0;
        if (kept_bytes[k] != BYTE_ALL1) all_high = 1'b0;
      end
      lv.report_ready   = 1'b1;
      lv.report_valid   = !(all_low || all_high);
      lv.controller_id  = kept_bytes[0];
      lv.buttons_first  = kept_bytes[1];
      lv.buttons_second = kept_bytes[2];
      lv.right_stick_x  = kept_bytes[3];
      lv.right_stick_y  = kept_bytes[4];
      lv.left_stick_x   = kept_bytes[5];
      lv.left_stick_y   = kept_bytes[6];
    end
    return lv;
  endfunction

  function automatic string show_levels(input line_levels_t s);
    return $sformatf("sel=%b clk=%b cmd=%b rdy=%b ok=%b id=%h btn=%h/%h rs=%h/%h ls=%h/%h",
                     s.select_level, s.clock_level, s.command_level, s.report_ready,
                     s.report_valid, s.controller_id, s.buttons_first, s.buttons_second,
                     s.right_stick_x, s.right_stick_y, s.left_stick_x, s.left_stick_y);
  endfunction

  task automatic flag_result(input string what, input string want_text, input line_levels_t seen);
    fail_count++;
    if (fail_count <= MAX_SHOWN) begin
      $display("%0t: %s", $time, what);
      $display("  expected %s", want_text);
      $display("  actual   %s", show_levels(seen));
    end
  endtask

  always @(posedge clk) begin
    line_levels_t seen;
    line_levels_t want;
    if (!rst_n) begin
      lead_span   = SELECT_LEAD_RST;
      setup_span  = DATA_SETUP_RST;
      high_span   = CLOCK_HIGH_RST;
      sample_span = SAMPLE_DELAY_RST;
      frame_phase = PH_IDLE;
      part_ticks  = '0;
      bit_pos     = '0;
      byte_pos    = '0;
      shift_in    = '0;
      for (int k = 0; k < RX_SLOTS; k++) kept_bytes[k] = '0;
      expected_lines.delete();
      fail_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SELECT_LEAD:  lead_span   = cfg_data;
          CFG_DATA_SETUP:   setup_span  = cfg_data;
          CFG_CLOCK_HIGH:   high_span   = cfg_data;
          CFG_SAMPLE_DELAY: sample_span = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_lines.push_back(next_line_levels(in_poll_request, in_data_in));
      if (out_valid && out_ready) begin
        seen = {out_select_level, out_clock_level, out_command_level, out_report_ready,
                out_report_valid, out_controller_id, out_buttons_first, out_buttons_second,
                out_right_stick_x, out_right_stick_y, out_left_stick_x, out_left_stick_y};
        if (expected_lines.size() == 0) begin
          flag_result("result item with no tick item waiting", "nothing", seen);
        end else begin
          want = expected_lines.pop_front();
          if (seen !== want) flag_result("result item mismatch", show_levels(want), seen);
        end
      end
    end
    outstanding = expected_lines.size();
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gspm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 20;

  // How the controller data line behaves over a stretch of ticks.
  typedef enum logic [1:0] {
    LINE_LOW,
    LINE_HIGH,
    LINE_SPARSE,
    LINE_NOISE
  } line_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_poll_request;
  logic                 in_data_in;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_select_level;
  logic                 out_clock_level;
  logic                 out_command_level;
  logic                 out_report_ready;
  logic                 out_report_valid;
  logic [7:0]           out_controller_id;
  logic [7:0]           out_buttons_first;
  logic [7:0]           out_buttons_second;
  logic [7:0]           out_right_stick_x;
  logic [7:0]           out_right_stick_y;
  logic [7:0]           out_left_stick_x;
  logic [7:0]           out_left_stick_y;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  line_mode_t  line_mode = LINE_NOISE;

  int unsigned idle_plan [4] = '{0, 60, 0, 32};
  int unsigned stall_plan [4] = '{0, 0, 60, 32};

  gamepad_serial_poll_master_unit i_dut (.*);

  gamepad_poll_line_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic put_tick(input logic req, input logic din);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_poll_request = req;
    in_data_in      = din;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_timing(input logic [7:0] lead, input logic [7:0] setup,
                              input logic [7:0] high, input logic [7:0] sample);
    write_reg(CFG_SELECT_LEAD, lead);
    write_reg(CFG_DATA_SETUP, setup);
    write_reg(CFG_CLOCK_HIGH, high);
    write_reg(CFG_SAMPLE_DELAY, sample);
  endtask

  // Sends the given number of tick items with random poll requests.
  task automatic run_ticks(input int unsigned count);
    logic din;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) == 0) line_mode = line_mode_t'($urandom_range(0, 3));
      case (line_mode)
        LINE_LOW:    din = 1'b0;
        LINE_HIGH:   din = 1'b1;
        LINE_SPARSE: din = ($urandom_range(0, 199) == 0);
        default:     din = 1'($urandom_range(0, 1));
      endcase
      put_tick($urandom_range(0, 3) == 0, din);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_SELECT_LEAD;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_poll_request = 1'b0;
    in_data_in      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Idle ticks, a frame start, then requests that land while the frame is busy.
    put_tick(1'b0, 1'b0);
    put_tick(1'b0, 1'b1);
    put_tick(1'b1, 1'b1);
    put_tick(1'b1, 1'b0);
    put_tick(1'b1, 1'b1);
    put_tick(1'b0, 1'b1);
    put_tick(1'b1, 1'b0);
    put_tick(1'b0, 1'b0);
    run_ticks(30);
    wait_drained();

    // The frame started above runs on through the next phases, so the shorter
    // timing takes effect in the middle of its lead time.
    write_timing(8'd1, 8'd1, 8'd1, 8'd1);
    idle_pct = 60;
    run_ticks(100);
    wait_drained();

    // Zero spans behave as one tick; writes past the last register are dropped.
    write_timing(8'd0, 8'd0, 8'd0, 8'd0);
    for (int k = int'(CFG_SAMPLE_DELAY) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), 8'($urandom));
    idle_pct  = 0;
    stall_pct = 60;
    run_ticks(130);
    wait_drained();

    write_timing(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                 8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
    idle_pct  = 32;
    stall_pct = 32;
    run_ticks(60);
    wait_drained();

    write_timing(8'd255, 8'd255, 8'd255, 8'd255);
    idle_pct  = 0;
    stall_pct = 0;
    run_ticks(16);
    wait_drained();

    for (int r = 0; r < 4; r++) begin
      write_timing(8'($urandom_range(1, 20)), 8'($urandom_range(0, 6)),
                   8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
      idle_pct  = idle_plan[r];
      stall_pct = stall_plan[r];
      run_ticks(12);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+design
design/gspm_pkg.sv
design/gamepad_serial_poll_master_unit.sv
verif/gamepad_poll_line_checker.sv
verif/testbench.sv
